// ===== rtl/core/crc_packet_framer_checker_unit_assert.svh =====
// Assertion macros for the framer/checker checker module.
`ifndef CRC_PACKET_FRAMER_CHECKER_UNIT_ASSERT_SVH
`define CRC_PACKET_FRAMER_CHECKER_UNIT_ASSERT_SVH

// Property checked at every edge, masked while reset is high.
`define CPFC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cpfc assertion failed");

// Property checked at every edge, reset included.
`define CPFC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cpfc assertion failed during reset");

`endif

// ===== rtl/core/cpfc_pkg.sv =====
// Shared types, constants and the byte-wide CRC step for the framer/checker.
package cpfc_pkg;

  localparam logic [15:0] PolyNarrow = 16'h8005;
  localparam logic [31:0] PolyWide   = 32'hEDB88320;
  localparam logic [7:0]  TagNack    = 8'd5;

  // Result status codes
  typedef enum logic [1:0] {
    ST_FRAME   = 2'd0,
    ST_OK      = 2'd1,
    ST_CRC_ERR = 2'd2,
    ST_NACK    = 2'd3
  } status_t;

  // One input beat
  typedef struct packed {
    logic       action;
    logic       use_wide_crc;
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [7:0] value;
    logic [1:0] status;
    logic       run_last;
  } out_beat_t;

  // Engine to output queue
  typedef struct packed {
    logic      push;
    out_beat_t res;
  } push_t;

  // Eight augmented, MSB-first shift steps of the CRC register.
  // Narrow mode keeps only the low 16 bits.
  function automatic logic [31:0] crc_byte_step(input logic [31:0] crc_in,
                                                input logic [7:0]  b,
                                                input logic        wide);
    logic [31:0] r;
    logic        top;
    r = crc_in;
    for (int i = 7; i >= 0; i--) begin
      top = wide ? r[31] : r[15];
      r = {r[30:0], b[i]};
      if (!wide) r[31:16] = '0;
      if (top) r = r ^ (wide ? PolyWide : {16'h0000, PolyNarrow});
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/cpfc_in_reg.sv =====
// Input register stage: holds one beat until the engine takes it.
module cpfc_in_reg
  import cpfc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item_in,
  input  logic  adv,
  output logic  a_valid,
  output item_t a_item
);

  // Stall only while a held beat cannot move on
  assign item_stall = a_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      a_valid <= 1'b1;
    end else if (adv) begin
      a_valid <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      a_item <= item_in;
    end
  end

endmodule

// ===== rtl/core/cpfc_out_fifo.sv =====
// Two-entry output queue; the head entry drives the result port.
module cpfc_out_fifo
  import cpfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  push_t     pin,
  output logic      room,
  output logic      result_valid,
  input  logic      result_stall,
  output out_beat_t head
);

  logic [1:0] cnt;
  logic [1:0] cnt_next;
  out_beat_t  second;
  logic       pop;

  assign room         = (cnt != 2'd2);
  assign result_valid = (cnt != 2'd0);
  assign pop          = result_valid && !result_stall;

  always_comb begin
    cnt_next = cnt;
    if (pin.push && !pop) cnt_next = cnt + 2'd1;
    else if (!pin.push && pop) cnt_next = cnt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // Head refills from the new beat or from the second entry
  always_ff @(posedge clk) begin
    if (pin.push && (cnt == 2'd0 || (pop && cnt == 2'd1))) begin
      head <= pin.res;
    end else if (pop && cnt == 2'd2) begin
      head <= second;
    end
    if (pin.push && cnt == 2'd1 && !pop) begin
      second <= pin.res;
    end
  end

endmodule

// ===== rtl/core/cpfc_engine.sv =====
// CRC engine: frame state, byte step, flush and check-byte sequencing.
module cpfc_engine
  import cpfc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  a_valid,
  input  item_t a_item,
  input  logic  room,
  output logic  adv,
  output push_t pout
);

  typedef enum logic [2:0] {
    S_RUN   = 3'b001,
    S_FLUSH = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t      state;
  logic [1:0]  cnt;
  logic [31:0] crc_register;
  logic        expecting_first;
  logic        frame_mode_check;
  logic        frame_wide_crc;
  logic        first_was_nack;

  logic        run;
  logic        mode_chk;
  logic        wide_sel;
  logic        nack;
  logic [31:0] step_in;
  logic [7:0]  step_byte;
  logic        step_wide;
  logic [31:0] step_out;
  logic [7:0]  emit_byte;
  status_t     chk_status;

  // Frame attributes come from the beat itself on the first byte
  assign run      = (state == S_RUN);
  assign mode_chk = expecting_first ? a_item.action : frame_mode_check;
  assign wide_sel = expecting_first ? a_item.use_wide_crc : frame_wide_crc;
  assign nack     = expecting_first ? (a_item.data_byte == TagNack) : first_was_nack;
  assign adv      = a_valid && run && room;

  // One shared byte step: data bytes while running, zero bytes while flushing
  assign step_in   = (run && expecting_first) ? 32'h0 : crc_register;
  assign step_byte = run ? a_item.data_byte : 8'h00;
  assign step_wide = run ? (wide_sel && !mode_chk) : frame_wide_crc;
  assign step_out  = crc_byte_step(step_in, step_byte, step_wide);

  // Residue check has priority over the NACK tag
  always_comb begin
    if (step_out != 32'h0) chk_status = ST_CRC_ERR;
    else if (nack) chk_status = ST_NACK;
    else chk_status = ST_OK;
  end

  // Check bytes leave most significant first
  always_comb begin
    case (cnt)
      2'd3:    emit_byte = crc_register[31:24];
      2'd2:    emit_byte = crc_register[23:16];
      2'd1:    emit_byte = crc_register[15:8];
      default: emit_byte = crc_register[7:0];
    endcase
  end

  // Result beat toward the output queue
  always_comb begin
    pout = '0;
    case (state)
      S_RUN: begin
        if (adv) begin
          if (mode_chk) begin
            pout.push         = a_item.last;
            pout.res.value    = 8'h00;
            pout.res.status   = chk_status;
            pout.res.run_last = 1'b1;
          end else begin
            pout.push         = 1'b1;
            pout.res.value    = a_item.data_byte;
            pout.res.status   = ST_FRAME;
            pout.res.run_last = !a_item.last;
          end
        end
      end
      S_EMIT: begin
        pout.push         = room;
        pout.res.value    = emit_byte;
        pout.res.status   = ST_FRAME;
        pout.res.run_last = (cnt == 2'd0);
      end
      default: pout = '0;
    endcase
  end

  // Frame state and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_RUN;
      cnt              <= 2'd0;
      crc_register     <= 32'h0;
      expecting_first  <= 1'b1;
      frame_mode_check <= 1'b0;
      frame_wide_crc   <= 1'b0;
      first_was_nack   <= 1'b0;
    end else begin
      case (state)
        S_RUN: begin
          if (adv) begin
            frame_mode_check <= mode_chk;
            frame_wide_crc   <= wide_sel;
            first_was_nack   <= nack;
            crc_register     <= step_out;
            expecting_first  <= a_item.last;
            if (a_item.last && !mode_chk) begin
              state <= S_FLUSH;
              cnt   <= wide_sel ? 2'd3 : 2'd1;
            end
          end
        end
        S_FLUSH: begin
          crc_register <= step_out;
          if (cnt == 2'd0) begin
            state <= S_EMIT;
            cnt   <= frame_wide_crc ? 2'd3 : 2'd1;
          end else begin
            cnt <= cnt - 2'd1;
          end
        end
        S_EMIT: begin
          if (room) begin
            if (cnt == 2'd0) state <= S_RUN;
            else cnt <= cnt - 2'd1;
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

endmodule

// ===== rtl/core/crc_packet_framer_checker_unit.sv =====
// Top level of the byte-serial CRC packet framer and checker.
//
// Input channel (item_valid / item_stall) carries one frame byte per beat with
// action, use_wide_crc and last; action and use_wide_crc count on the first
// byte of a frame only. Output channel (result_valid / result_stall) carries
// value, status and run_last.
// Frame mode echoes each byte; after the last byte the CRC-16 (2 bytes) or the
// 32-bit check (4 bytes) follows, most significant byte first. Check mode
// gives one status beat on the last byte and nothing for other bytes.
// The first result of a beat leaves through the input register, then the
// output queue head. Throughput: one byte per cycle while the output queue
// has room and no check bytes are pending; the byte step is eight unrolled
// shift steps. A last byte in frame mode holds the input while its N = 2 or 4
// check bytes are made: a zero-byte flush of N bytes, then N emit beats.
// Reset clears the CRC register and frame state; the next byte is a first
// byte. While the receiver stalls, the two-entry output queue keeps taking
// results until full, then the input stalls; nothing is dropped.
module crc_packet_framer_checker_unit
  import cpfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       action,
  input  logic       use_wide_crc,
  input  logic [7:0] data_byte,
  input  logic       last,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] value,
  output logic [1:0] status,
  output logic       run_last
);

  item_t     item_in;
  item_t     a_item;
  logic      a_valid;
  logic      adv;
  logic      room;
  push_t     pbeat;
  out_beat_t head;

  assign item_in.action       = action;
  assign item_in.use_wide_crc = use_wide_crc;
  assign item_in.data_byte    = data_byte;
  assign item_in.last         = last;

  cpfc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_in    (item_in),
    .adv        (adv),
    .a_valid    (a_valid),
    .a_item     (a_item)
  );

  cpfc_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .a_valid (a_valid),
    .a_item  (a_item),
    .room    (room),
    .adv     (adv),
    .pout    (pbeat)
  );

  cpfc_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .pin          (pbeat),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .head         (head)
  );

  assign value    = head.value;
  assign status   = head.status;
  assign run_last = head.run_last;

endmodule

// ===== rtl/core/cpfc_checker.sv =====
// Port-level assertions for the framer/checker and their bind.
`include "crc_packet_framer_checker_unit_assert.svh"

module cpfc_checker
  import cpfc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic [7:0] value,
  input logic [1:0] status,
  input logic       run_last
);

  // Nothing pending right after reset
  `CPFC_ASSERT_ALWAYS(a_rst_no_result, rst |=> !result_valid)
  `CPFC_ASSERT_ALWAYS(a_rst_no_stall, rst |=> !item_stall)
  // A status beat carries a zero value and closes its item
  `CPFC_ASSERT(a_status_zero, (result_valid && status != ST_FRAME) |-> value == 8'h00)
  `CPFC_ASSERT(a_status_last, (result_valid && status != ST_FRAME) |-> run_last)
  // Stalled result beat holds
  `CPFC_ASSERT(a_hold, (result_valid && result_stall) |=> (result_valid && $stable(value) && $stable(status) && $stable(run_last)))

endmodule

bind crc_packet_framer_checker_unit cpfc_checker u_cpfc_checker (.*);

// ===== tb/crc_packet_framer_checker_unit_tb.sv =====
// Self-checking testbench for the byte-serial CRC packet framer and checker.
module crc_packet_framer_checker_unit_tb;
  import cpfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit   = 200000;
  localparam int RandomItems  = 330;
  localparam int MaxMsgPrints = 20;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_RUNS,
    STALL_HEAVY
  } stall_mode_t;

  logic       clk;
  logic       rst;
  logic       item_valid;
  logic       item_stall;
  logic       action;
  logic       use_wide_crc;
  logic [7:0] data_byte;
  logic       last;
  logic       result_valid;
  logic       result_stall;
  logic [7:0] value;
  logic [1:0] status;
  logic       run_last;

  crc_packet_framer_checker_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .use_wide_crc (use_wide_crc),
    .data_byte    (data_byte),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value        (value),
    .status       (status),
    .run_last     (run_last)
  );

  // Shadow framer state
  logic [31:0] shadow_crc;
  logic        shadow_first;
  logic        shadow_check;
  logic        shadow_wide;
  logic        shadow_nack;

  out_beat_t expected_beats[$];

  int mismatch_count;
  int beats_checked;
  int items_sent;
  int frames_built;
  int frames_checked;
  int cycle_count;
  int burst_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats still pending", cycle_count,
               expected_beats.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Eight MSB-first augmented shift steps; narrow keeps 16 bits
  function automatic logic [31:0] crc_advance(input logic [31:0] crc_in,
                                              input logic [7:0]  b,
                                              input logic        wide);
    logic [31:0] acc;
    logic        msb;
    acc = crc_in;
    for (int k = 0; k < 8; k++) begin
      msb = wide ? acc[31] : acc[15];
      acc = {acc[30:0], b[7-k]};
      if (wide) begin
        if (msb) acc = acc ^ PolyWide;
      end else begin
        acc = {16'h0000, acc[15:0] ^ (msb ? PolyNarrow : 16'h0000)};
      end
    end
    return acc;
  endfunction

  // Flushed CRC-16 of a byte string, as a sender would append it
  function automatic logic [15:0] crc16_trailer(input logic [7:0] bytes[$]);
    logic [31:0] acc;
    acc = '0;
    foreach (bytes[i]) acc = crc_advance(acc, bytes[i], 1'b0);
    acc = crc_advance(acc, 8'h00, 1'b0);
    acc = crc_advance(acc, 8'h00, 1'b0);
    return acc[15:0];
  endfunction

  // Expected result beats for one accepted input beat
  function automatic void predict_beats(input logic act, input logic wide,
                                        input logic [7:0] b, input logic lst);
    out_beat_t r;
    int        nbytes;
    if (shadow_first) begin
      shadow_crc   = '0;
      shadow_check = act;
      shadow_wide  = wide;
      shadow_nack  = (b == TagNack);
      shadow_first = 1'b0;
    end
    if (shadow_check) begin
      shadow_crc = crc_advance(shadow_crc, b, 1'b0);
      if (lst) begin
        r.value    = 8'h00;
        r.status   = (shadow_crc != 0) ? ST_CRC_ERR : (shadow_nack ? ST_NACK : ST_OK);
        r.run_last = 1'b1;
        expected_beats.push_back(r);
        shadow_first = 1'b1;
      end
    end else begin
      shadow_crc = crc_advance(shadow_crc, b, shadow_wide);
      r.value    = b;
      r.status   = ST_FRAME;
      r.run_last = !lst;
      expected_beats.push_back(r);
      if (lst) begin
        nbytes = shadow_wide ? 4 : 2;
        for (int i = 0; i < nbytes; i++) shadow_crc = crc_advance(shadow_crc, 8'h00, shadow_wide);
        for (int i = nbytes - 1; i >= 0; i--) begin
          r.value    = shadow_crc[i*8 +: 8];
          r.status   = ST_FRAME;
          r.run_last = (i == 0);
          expected_beats.push_back(r);
        end
        shadow_first = 1'b1;
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MaxMsgPrints) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Output checker: compare every accepted result beat with the oldest expectation
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat value=%02h status=%0d run_last=%0b",
                                  value, status, run_last));
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        if (value !== want.value)
          report_mismatch($sformatf("value %02h, expected %02h", value, want.value));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (run_last !== want.run_last)
          report_mismatch($sformatf("run_last %0b, expected %0b", run_last, want.run_last));
      end
    end
  end

  // Receiver stall pattern: the mode changes at random between none, light, runs and heavy
  initial begin
    stall_mode_t mode;
    int          mode_left;
    int          run_left;
    mode      = STALL_NONE;
    mode_left = 0;
    run_left  = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      case (mode)
        STALL_NONE:  result_stall = 1'b0;
        STALL_LIGHT: result_stall = ($urandom_range(0, 9) < 3);
        STALL_HEAVY: result_stall = ($urandom_range(0, 9) < 7);
        default: begin
          if (run_left == 0) begin
            run_left     = $urandom_range(1, 8);
            result_stall = ~result_stall;
          end
          run_left--;
        end
      endcase
    end
  end

  // Drive one input beat, with bursts and gaps, and wait for acceptance
  task automatic send_beat(input logic act, input logic wide,
                           input logic [7:0] b, input logic lst);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        item_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item_valid   = 1'b1;
    action       = act;
    use_wide_crc = wide;
    data_byte    = b;
    last         = lst;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_beats(act, wide, b, lst);
    items_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  // Send a whole frame; control bits on later bytes are random when scrambled
  task automatic send_frame(input logic act, input logic wide,
                            input logic [7:0] bytes[$], input logic scramble);
    logic a;
    logic w;
    foreach (bytes[i]) begin
      a = act;
      w = wide;
      if (i > 0 && scramble) begin
        a = 1'($urandom_range(0, 1));
        w = 1'($urandom_range(0, 1));
      end
      send_beat(a, w, bytes[i], i == bytes.size() - 1);
    end
    if (act) frames_checked++;
    else frames_built++;
  endtask

  // Check frame: content plus its CRC-16, optionally with one bit flipped
  task automatic send_check(input logic wide, input logic [7:0] content[$],
                            input logic corrupt);
    logic [7:0] bytes[$];
    logic [15:0] trailer;
    int          pos;
    bytes   = content;
    trailer = crc16_trailer(content);
    bytes.push_back(trailer[15:8]);
    bytes.push_back(trailer[7:0]);
    if (corrupt) begin
      pos        = $urandom_range(0, bytes.size() - 1);
      bytes[pos] = bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    send_frame(1'b1, wide, bytes, 1'b1);
  endtask

  // Directed frame building: byte extremes, both check widths, one-byte frames
  task automatic test_frame_directed();
    logic [7:0] bytes[$];
    // later bytes carry flipped control bits, which must be ignored
    send_beat(1'b0, 1'b0, 8'h00, 1'b0);
    send_beat(1'b1, 1'b1, 8'hFF, 1'b0);
    send_beat(1'b1, 1'b0, 8'h80, 1'b1);
    frames_built++;
    bytes = '{8'hFF};
    send_frame(1'b0, 1'b1, bytes, 1'b0);
    bytes = '{TagNack, 8'h01};
    send_frame(1'b0, 1'b1, bytes, 1'b0);
    bytes = '{8'h00};
    send_frame(1'b0, 1'b0, bytes, 1'b0);
  endtask

  // Directed checking: good frame, NACK tag, CRC error priority, one-byte frames
  task automatic test_check_directed();
    logic [7:0] bytes[$];
    bytes = '{8'h11, 8'h01, 8'hA5};
    send_check(1'b0, bytes, 1'b0);
    // wide flag is latched but checking stays CRC-16
    bytes = '{TagNack, 8'h00};
    send_check(1'b1, bytes, 1'b0);
    // bad residue wins over the NACK tag
    bytes = '{TagNack, 8'h00, 8'h12, 8'h34};
    send_frame(1'b1, 1'b0, bytes, 1'b0);
    bytes = '{8'h00};
    send_frame(1'b1, 1'b0, bytes, 1'b0);
    bytes = '{TagNack};
    send_frame(1'b1, 1'b0, bytes, 1'b0);
  endtask

  // Random traffic: mostly well-formed frames, some corrupt and noise frames
  task automatic test_random_traffic();
    logic [7:0] bytes[$];
    int         kind;
    int         plen;
    int         target;
    target = items_sent + RandomItems;
    while (items_sent < target) begin
      kind = $urandom_range(0, 99);
      plen = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
      bytes.delete();
      bytes.push_back(($urandom_range(0, 5) == 0) ? TagNack : 8'($urandom()));
      if (plen > 0) bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'(plen - 1));
      for (int i = 1; i < plen; i++) bytes.push_back(8'($urandom()));
      if (kind < 35)      send_frame(1'b0, 1'b0, bytes, 1'b1);
      else if (kind < 55) send_frame(1'b0, 1'b1, bytes, 1'b1);
      else if (kind < 80) send_check(1'($urandom_range(0, 1)), bytes, 1'b0);
      else if (kind < 92) send_check(1'($urandom_range(0, 1)), bytes, 1'b1);
      else                send_frame(1'b1, 1'($urandom_range(0, 1)), bytes, 1'b1);
    end
    release_input();
  endtask

  initial begin
    rst            = 1'b1;
    item_valid     = 1'b0;
    action         = 1'b0;
    use_wide_crc   = 1'b0;
    data_byte      = 8'h00;
    last           = 1'b0;
    result_stall   = 1'b0;
    shadow_crc     = '0;
    shadow_first   = 1'b1;
    shadow_check   = 1'b0;
    shadow_wide    = 1'b0;
    shadow_nack    = 1'b0;
    mismatch_count = 0;
    beats_checked  = 0;
    items_sent     = 0;
    frames_built   = 0;
    frames_checked = 0;
    burst_left     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_frame_directed();
    test_check_directed();
    test_random_traffic();

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("covered %0d input beats: %0d frames built, %0d frames checked",
             items_sent, frames_built, frames_checked);
    $display("compared %0d result beats, %0d mismatches", beats_checked, mismatch_count);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
